### hw/rtl/icf_pkg.sv
package icf_pkg;

	// Default CORDIC iteration count
	localparam int CORDIC_STEPS_DEF = 24;

	// Iteration counts of the sequential divider and square root
	localparam int DIV_STEPS  = 8;
	localparam int SQRT_STEPS = 32;
	localparam int CNT_W      = 6;

	// CORDIC working widths: vector components and Q2.30 angle accumulator
	localparam int CW = 40;
	localparam int ZW = 35;

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic [14:0] DIV_K      = 15'd15625;
	// Reciprocal of 15625 scaled by 2^44, exact for 30-bit partial dividends
	localparam logic [30:0] DIV_M      = 31'd1125899907;
	// Smallest dividend whose quotient exceeds 2^40
	localparam logic [69:0] DIV_T      = 70'd17179869184015625;
	localparam logic [16:0] W_ONE      = 17'd65536;
	localparam logic [40:0] D_MAX      = 41'h100_0000_0000;

	// Register reset values
	localparam logic [16:0]        BLEND_RST = 17'd64225;
	localparam logic signed [31:0] YAW_RST   = 32'sd52680458;

	// Register index codes (paddr bit 2)
	localparam logic REG_BLEND = 1'b0;
	localparam logic REG_YAW   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_GMUL, ST_GSUM, ST_GDIV, ST_GUPD, ST_GTIME,
		ST_ASQ, ST_ASUM, ST_ASQRT, ST_APREP, ST_ACORD, ST_AFIN, ST_BUPD, ST_DONE
	} state_t;

	typedef struct packed {
		logic             load;
		logic             gmul;
		logic             gsum;
		logic             gdiv;
		logic             gupd;
		logic             gtime;
		logic             asq;
		logic             asum;
		logic             asqrt;
		logic             aprep;
		logic             acord;
		logic             ainit;
		logic             bmul;
		logic             bupd;
		logic             outld;
		logic [CNT_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic is_accel;
		logic started;
		logic time_valid;
	} dp_stat_t;

	// Q2.30 arctangent of 2^-i
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'd843314857;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043837;
			5'd3:    r = 30'd133525159;
			5'd4:    r = 30'd67021687;
			5'd5:    r = 30'd33543516;
			5'd6:    r = 30'd16775851;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194283;
			5'd9:    r = 30'd2097149;
			5'd31:   r = 30'd0;
			default: r = 30'd1 << (5'd30 - i);
		endcase
		return r;
	endfunction

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		if (v > 51'sd2147483647)
			r = 32'sh7fff_ffff;
		else if (v < -51'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

### hw/rtl/icf_ctrl.sv
module icf_ctrl
	import icf_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             ov_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_DISP;
			ST_DISP: begin
				if (stat.is_accel)
					state_d = ST_ASQ;
				else if (stat.started && stat.time_valid)
					state_d = ST_GMUL;
				else
					state_d = ST_GTIME;
			end
			ST_GMUL:  state_d = ST_GSUM;
			ST_GSUM:  state_d = ST_GDIV;
			ST_GDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_GUPD;
			ST_GUPD:  state_d = ST_DONE;
			ST_GTIME: state_d = ST_DONE;
			ST_ASQ:   state_d = ST_ASUM;
			ST_ASUM:  state_d = ST_ASQRT;
			ST_ASQRT: if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_APREP;
			ST_APREP: state_d = ST_ACORD;
			ST_ACORD: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_AFIN;
			ST_AFIN:  state_d = stat.started ? ST_BUPD : ST_DONE;
			ST_BUPD:  state_d = ST_DONE;
			ST_DONE:  if (!ov_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd      = '0;
		cmd.step = cnt_q;
		case (state_q)
			ST_IDLE:  cmd.load  = s_tvalid;
			ST_GMUL:  cmd.gmul  = 1'b1;
			ST_GSUM:  cmd.gsum  = 1'b1;
			ST_GDIV:  cmd.gdiv  = 1'b1;
			ST_GUPD: begin
				cmd.gupd  = 1'b1;
				cmd.gtime = 1'b1;
			end
			ST_GTIME: cmd.gtime = 1'b1;
			ST_ASQ:   cmd.asq   = 1'b1;
			ST_ASUM:  cmd.asum  = 1'b1;
			ST_ASQRT: cmd.asqrt = 1'b1;
			ST_APREP: cmd.aprep = 1'b1;
			ST_ACORD: cmd.acord = 1'b1;
			ST_AFIN: begin
				cmd.ainit = !stat.started;
				cmd.bmul  = stat.started;
			end
			ST_BUPD:  cmd.bupd  = 1'b1;
			ST_DONE:  cmd.outld = !ov_q || m_tready;
			default:  cmd.load  = 1'b0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ov_q;

	// State, iteration counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (cmd.outld)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GDIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> (state_q == ST_GUPD))
		else $error("divider did not hand over after its last step");
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DISP))
		else $error("accepted transaction not dispatched");
	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACORD) |-> (cnt_q < CNT_W'(CORDIC_STEPS)))
		else $error("CORDIC ran past its step count");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && ov_q && !m_tready) |=> (state_q == ST_DONE && ov_q))
		else $error("result overwritten while output stalled");
`endif

endmodule

### hw/rtl/icf_dp.sv
module icf_dp
	import icf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [95:0]        s_tdata,
	input  logic               s_tuser,
	input  logic [16:0]        blend_weight,
	input  logic signed [31:0] initial_yaw,
	output logic [95:0]        m_tdata,
	output logic               m_tuser
);

	// Captured item
	logic               acc_q;
	logic signed [15:0] sx_q, sy_q, sz_q;
	logic [47:0]        ts_q;

	// Filter state
	logic signed [31:0] ang_q [3];
	logic               started_q, tvalid_q;
	logic [47:0]        last_q;

	// Gyro lanes (0: x, 1: y, 2: z)
	logic [47:0]        dt;
	logic [15:0]        mag [3];
	logic               gneg [3];
	logic [39:0]        plo_q [3], phi_q [3];
	logic               gneg_q [3];
	logic [63:0]        num_q [3];
	logic [13:0]        rem_q [3];
	logic [15:0]        dig_q [3];
	logic               sat_q [3];

	// Square root
	logic [30:0]        sqy_q, sqz_q;
	logic [63:0]        rad_q;
	logic [33:0]        srem_q;
	logic [31:0]        root_q;

	// CORDIC lanes (0: x tilt, 1: z tilt)
	logic signed [CW-1:0] cx_q [2], cy_q [2];
	logic signed [ZW-1:0] cz_q [2];
	logic                 zero_q [2];
	logic signed [31:0]   cres [2];

	// Blend products
	logic signed [49:0] po_q [2], pa_q [2];
	logic [16:0]        wc;

	logic [95:0] m_tdata_q;
	logic        m_tuser_q;

	assign dt = ts_q - last_q;
	assign wc = (blend_weight > W_ONE) ? W_ONE : blend_weight;

	// Rate magnitude and sign per lane
	always_comb begin
		logic signed [16:0] v [3];
		v[0] = 17'(sz_q);
		v[1] = 17'(sy_q);
		v[2] = 17'(sx_q);
		for (int k = 0; k < 3; k++) begin
			logic [16:0] a;
			a = v[k][16] ? 17'(-v[k]) : 17'(v[k]);
			mag[k] = a[15:0];
		end
		gneg[0] = !v[0][16] && (v[0] != 17'sd0);
		gneg[1] = !v[1][16] && (v[1] != 17'sd0);
		gneg[2] = v[2][16];
	end

	// CORDIC result to Q8.24
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			logic signed [ZW-1:0] t;
			t = (cz_q[k] + $signed(ZW'(32))) >>> 6;
			cres[k] = zero_q[k] ? 32'sd0 : t[31:0];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			tvalid_q  <= 1'b0;
			last_q    <= '0;
			for (int k = 0; k < 3; k++)
				ang_q[k] <= '0;
		end else begin
			if (cmd.gtime) begin
				last_q   <= ts_q;
				tvalid_q <= 1'b1;
			end
			// Apply rate times elapsed time
			if (cmd.gupd) begin
				for (int k = 0; k < 3; k++) begin
					logic [40:0]        d;
					logic signed [42:0] sd;
					d  = sat_q[k] ? D_MAX : num_q[k][40:0];
					sd = gneg_q[k] ? -$signed({2'b00, d}) : $signed({2'b00, d});
					ang_q[k] <= sat32(51'(ang_q[k]) + 51'(sd));
				end
			end
			// Load angles on the first accel sample
			if (cmd.ainit) begin
				started_q <= 1'b1;
				ang_q[0]  <= cres[0];
				ang_q[1]  <= initial_yaw;
				ang_q[2]  <= cres[1];
			end
			// Blend tilt into the held angles
			if (cmd.bupd) begin
				for (int k = 0; k < 2; k++) begin
					logic signed [50:0] v;
					v = 51'(po_q[k]) + 51'(pa_q[k]) + 51'sd32768;
					ang_q[2*k] <= sat32(v >>> 16);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= s_tuser;
			sx_q  <= s_tdata[15:0];
			sy_q  <= s_tdata[31:16];
			sz_q  <= s_tdata[47:32];
			ts_q  <= s_tdata[95:48];
		end

		// Rate by elapsed time, split into two partial products
		if (cmd.gmul) begin
			for (int k = 0; k < 3; k++) begin
				plo_q[k]  <= 40'(mag[k]) * 40'(dt[23:0]);
				phi_q[k]  <= 40'(mag[k]) * 40'(dt[47:24]);
				gneg_q[k] <= gneg[k];
			end
		end

		// Form the dividend and flag quotients beyond the clamp
		if (cmd.gsum) begin
			for (int k = 0; k < 3; k++) begin
				logic [63:0] p;
				logic [69:0] nn;
				p  = {phi_q[k][39:0], 24'd0} + 64'(plo_q[k]);
				nn = {p, 6'd0} + 70'd7812;
				num_q[k] <= nn[63:0];
				rem_q[k] <= '0;
				sat_q[k] <= (nn >= DIV_T);
			end
		end

		// One 16-bit quotient digit in two steps: reciprocal estimate, then remainder;
		// digits shift into the dividend register
		if (cmd.gdiv) begin
			for (int k = 0; k < 3; k++) begin
				logic [29:0] t;
				logic [60:0] pr;
				logic [29:0] qk;
				t = {rem_q[k], num_q[k][63:48]};
				if (!cmd.step[0]) begin
					pr = 61'(t) * 61'(DIV_M);
					dig_q[k] <= pr[59:44];
				end else begin
					qk = 30'(dig_q[k]) * 30'(DIV_K);
					rem_q[k] <= 14'(t - qk);
					num_q[k] <= {num_q[k][47:0], dig_q[k]};
				end
			end
		end

		// Squares for the root
		if (cmd.asq) begin
			logic signed [31:0] py, pz;
			py = 32'(sy_q) * 32'(sy_q);
			pz = 32'(sz_q) * 32'(sz_q);
			sqy_q <= py[30:0];
			sqz_q <= pz[30:0];
		end

		if (cmd.asum) begin
			rad_q  <= {32'(sqy_q) + 32'(sqz_q), 32'd0};
			srem_q <= '0;
			root_q <= '0;
		end

		// One root bit per cycle
		if (cmd.asqrt) begin
			logic [35:0] rem2, trial;
			logic        ge;
			rem2  = {srem_q, rad_q[63:62]};
			trial = {2'b00, root_q, 2'b01};
			ge    = (rem2 >= trial);
			srem_q <= ge ? 34'(rem2 - trial) : rem2[33:0];
			root_q <= {root_q[30:0], ge};
			rad_q  <= {rad_q[61:0], 2'b00};
		end

		// Load CORDIC vectors, fold the left half plane
		if (cmd.aprep) begin
			logic signed [CW-1:0] x [2], y [2];
			y[0] = CW'(sx_q) <<< 16;
			x[0] = $signed(CW'(root_q));
			y[1] = CW'(sy_q) <<< 16;
			x[1] = CW'(sz_q) <<< 16;
			for (int k = 0; k < 2; k++) begin
				zero_q[k] <= (x[k] == '0) && (y[k] == '0);
				if (x[k] < 0) begin
					cx_q[k] <= -x[k];
					cy_q[k] <= -y[k];
					cz_q[k] <= (y[k] >= 0) ? PI_Q30 : -PI_Q30;
				end else begin
					cx_q[k] <= x[k];
					cy_q[k] <= y[k];
					cz_q[k] <= '0;
				end
			end
		end

		// Rotate towards the x axis
		if (cmd.acord) begin
			for (int k = 0; k < 2; k++) begin
				logic signed [CW-1:0] xs, ys;
				logic signed [ZW-1:0] at;
				xs = cx_q[k] >>> cmd.step[4:0];
				ys = cy_q[k] >>> cmd.step[4:0];
				at = $signed(ZW'(atan_q30(cmd.step[4:0])));
				if (!cy_q[k][CW-1]) begin
					cx_q[k] <= cx_q[k] + ys;
					cy_q[k] <= cy_q[k] - xs;
					cz_q[k] <= cz_q[k] + at;
				end else begin
					cx_q[k] <= cx_q[k] - ys;
					cy_q[k] <= cy_q[k] + xs;
					cz_q[k] <= cz_q[k] - at;
				end
			end
		end

		// Weighted old and new angle
		if (cmd.bmul) begin
			for (int k = 0; k < 2; k++) begin
				po_q[k] <= 50'(ang_q[2*k]) * $signed({33'd0, wc});
				pa_q[k] <= 50'(cres[k]) * $signed({33'd0, 17'(W_ONE - wc)});
			end
		end

		if (cmd.outld) begin
			m_tdata_q <= {ang_q[2], ang_q[1], ang_q[0]};
			m_tuser_q <= started_q;
		end
	end

	assign stat.is_accel   = acc_q;
	assign stat.started    = started_q;
	assign stat.time_valid = tvalid_q;
	assign m_tdata         = m_tdata_q;
	assign m_tuser         = m_tuser_q;

endmodule

### hw/rtl/imu_complementary_tilt_filter.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: sample x, y, z, timestamp; tuser: cmd
// m_*       out        m_tvalid/m_tready  tdata: angle x, y, z; tuser: out_ready
// apb       in         psel/penable       blend_weight @0x0, initial_yaw @0x4
//
// A gyro item with a usable timestamp is scaled by elapsed time and divided by 15625,
// one reciprocal digit in two steps; one that only records its time skips the arithmetic.
// An accel item runs a 32-step root, then the CORDIC lanes, then the blend, which the
// first one skips: it loads the angles instead.
// A new item is taken once the previous one is in the output register; a stalled
// output holds the following item in its last state. Reset clears all angles.
module imu_complementary_tilt_filter
	import icf_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // sample_x, sample_y, sample_z, timestamp_us
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // out_angle_x, out_angle_y, out_angle_z
	output logic        m_tuser,  // out_ready
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [16:0]        bw_q;
	logic signed [31:0] yaw_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q  <= BLEND_RST;
			yaw_q <= YAW_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_YAW)
				yaw_q <= pwdata;
			else
				bw_q <= pwdata[16:0];
		end
	end

	assign prdata = (paddr[2] == REG_YAW) ? yaw_q : {15'd0, bw_q};

	icf_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	icf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.blend_weight (bw_q),
		.initial_yaw  (yaw_q),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule
